// ----- hdl/gaussian_pair_affinity_macros.svh -----
// assertion helpers for the gaussian pair affinity block
`ifndef GAUSSIAN_PAIR_AFFINITY_MACROS_SVH
`define GAUSSIAN_PAIR_AFFINITY_MACROS_SVH
`ifndef SYNTHESIS
`define GPA_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
`define GPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GPA_ASSERT(lbl, expr)
`define GPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/gpa_pkg.sv -----
`timescale 1ns / 1ps
package gpa_pkg;
  localparam int SumW = 48;
  localparam int FracBits = 20;
  localparam int MaxPatches = 1024;
  localparam int MaxFeatureElems = 4096;
  localparam logic [20:0] Log2eQ20 = 21'd1512775;

  localparam logic [2:0] RegFeatureLength = 3'd0;
  localparam logic [2:0] RegPositionLength = 3'd1;
  localparam logic [2:0] RegFeatureWidth = 3'd2;
  localparam logic [2:0] RegPositionWidth = 3'd3;
  localparam logic [2:0] RegPatchCount = 3'd4;

  typedef struct packed {
    logic [12:0] feature_length;
    logic [4:0]  position_length;
    logic [7:0]  feature_width;
    logic [7:0]  position_width;
    logic [10:0] patch_count;
  } cfg_t;

  typedef struct packed {
    logic [SumW-1:0] feature_sum;
    logic [SumW-1:0] position_sum;
    logic [19:0]     entry_index;
  } pair_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] vv;
    r = '0;
    b = 64'd1 << 62;
    vv = v;
    for (int i = 0; i < 32; i++) begin
      if (vv >= r + b) begin
        vv = vv - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // factor 2^-(2^-(k+1)) in q1.31 by repeated roots of one half
  function automatic logic [31:0] root_entry(int k);
    logic [63:0] c;
    c = 64'd1 << 30;
    for (int i = 0; i <= k; i++) begin
      c = isqrt64(c << 31);
    end
    return c[31:0];
  endfunction
endpackage

// ----- hdl/gpa_front.sv -----
`timescale 1ns / 1ps
module gpa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       elem_a_i,
  input  logic [15:0]       elem_b_i,
  input  logic              is_position_i,
  input  logic              last_of_pair_i,
  input  logic [9:0]        row_i,
  input  logic [9:0]        col_i,
  input  logic [10:0]       patch_count_i,
  input  logic              q_full_i,
  output logic              push_o,
  output gpa_pkg::pair_t    pair_o
);
  import gpa_pkg::*;

  logic [SumW-1:0] fsum_q, fsum_d, psum_q, psum_d;
  logic signed [16:0] diff;
  logic [16:0] mag;
  logic [33:0] sq;
  logic [SumW:0] fadd, padd;
  logic [SumW-1:0] fsat, psat;
  logic [10:0] pc_eff;
  logic [20:0] colpc;
  logic accept;

  assign in_ready_o = !q_full_i;
  assign accept = in_valid_i && in_ready_o;

  assign diff = $signed({elem_a_i[15], elem_a_i}) - $signed({elem_b_i[15], elem_b_i});
  assign mag = diff[16] ? 17'(-diff) : 17'(diff);
  assign sq = 34'(mag) * 34'(mag);

  assign fadd = {1'b0, fsum_q} + {15'd0, (is_position_i ? 34'd0 : sq)};
  assign padd = {1'b0, psum_q} + {15'd0, (is_position_i ? sq : 34'd0)};
  assign fsat = fadd[SumW] ? '1 : fadd[SumW-1:0];
  assign psat = padd[SumW] ? '1 : padd[SumW-1:0];

  assign pc_eff = (patch_count_i > 11'(MaxPatches)) ? 11'(MaxPatches) : patch_count_i;
  assign colpc = 21'(col_i) * 21'(pc_eff);

  always_comb begin
    fsum_d = fsum_q;
    psum_d = psum_q;
    if (accept) begin
      fsum_d = last_of_pair_i ? '0 : fsat;
      psum_d = last_of_pair_i ? '0 : psat;
    end
  end

  // diagonal pairs still clear the sums but queue nothing
  assign push_o = accept && last_of_pair_i && (row_i != col_i);
  assign pair_o.feature_sum = fsat;
  assign pair_o.position_sum = psat;
  assign pair_o.entry_index = 20'({11'd0, row_i} + colpc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsum_q <= '0;
      psum_q <= '0;
    end else begin
      fsum_q <= fsum_d;
      psum_q <= psum_d;
    end
  end
endmodule

// ----- hdl/gpa_fifo.sv -----
`timescale 1ns / 1ps
module gpa_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gpa_pkg::pair_t data_i,
  input  logic           pop_i,
  output gpa_pkg::pair_t data_o,
  output logic           full_o,
  output logic           empty_o
);
  import gpa_pkg::*;

  pair_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

// ----- hdl/gpa_back.sv -----
`timescale 1ns / 1ps
module gpa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gpa_pkg::cfg_t  cfg_i,
  input  logic           q_empty_i,
  input  gpa_pkg::pair_t pair_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [19:0]    entry_index_o,
  output logic [15:0]    weight_o
);
  import gpa_pkg::*;
  `include "gaussian_pair_affinity_macros.svh"

  typedef enum logic [3:0] {
    StIdle, StMul1, StMul2, StDiv, StLog, StExp, StShift, StProd, StFin
  } state_e;

  localparam logic [31:0] RootTab [FracBits] = '{
    root_entry(0), root_entry(1), root_entry(2), root_entry(3), root_entry(4),
    root_entry(5), root_entry(6), root_entry(7), root_entry(8), root_entry(9),
    root_entry(10), root_entry(11), root_entry(12), root_entry(13), root_entry(14),
    root_entry(15), root_entry(16), root_entry(17), root_entry(18), root_entry(19)
  };

  state_e state_q;
  logic sel_q;
  logic [20:0] lw_q;
  logic [28:0] d_q;
  logic [33:0] rem_q;
  logic [SumW-1:0] quo_q;
  logic [5:0] cnt_q;
  logic [26:0] t_q;
  logic [31:0] acc_q, ef_q, ep_q;
  logic [62:0] prod_q;
  logic out_valid_q;
  logic [19:0] idx_q;
  logic [15:0] wt_q;

  logic [12:0] len;
  logic [7:0] w;
  logic [33:0] rem_sh, dvs;
  logic ge;
  logic [25:0] x;
  logic [46:0] xt;
  logic [63:0] accp;
  logic [4:0] k;
  logic [31:0] root;
  logic [6:0] n;
  logic [31:0] kval;
  logic [31:0] pround;
  logic [16:0] wround;
  logic fin_load;

  always_comb begin
    if (sel_q) begin
      len = (cfg_i.position_length == '0) ? 13'd1 : {8'd0, cfg_i.position_length};
      w = (cfg_i.position_width == '0) ? 8'd1 : cfg_i.position_width;
    end else begin
      len = (cfg_i.feature_length == '0) ? 13'd1 :
            (cfg_i.feature_length > 13'(MaxFeatureElems)) ? 13'(MaxFeatureElems) :
            cfg_i.feature_length;
      w = (cfg_i.feature_width == '0) ? 8'd1 : cfg_i.feature_width;
    end
  end

  // restoring divide by 16*len*w*w, one quotient bit a cycle
  assign dvs = {1'b0, d_q, 4'd0};
  assign rem_sh = {rem_q[32:0], quo_q[SumW-1]};
  assign ge = rem_sh >= dvs;
  assign x = (|quo_q[SumW-1:26]) ? '1 : quo_q[25:0];
  assign xt = 47'(x) * 47'(Log2eQ20);

  assign k = cnt_q[4:0];
  assign root = RootTab[k];
  assign accp = 64'(acc_q) * 64'(root);
  assign n = t_q[26:20];
  assign kval = (n >= 7'd32) ? 32'd0 : (acc_q >> n[4:0]);

  assign pround = 32'((prod_q + 63'(64'd1 << 30)) >> 31);
  assign wround = 17'((33'(pround) + 33'd16384) >> 15);
  assign fin_load = (state_q == StFin) && (!out_valid_q || out_ready_i);
  assign pop_o = fin_load;

  assign out_valid_o = out_valid_q;
  assign entry_index_o = idx_q;
  assign weight_o = wt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sel_q <= 1'b0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      lw_q <= '0;
      d_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      t_q <= '0;
      acc_q <= '0;
      ef_q <= '0;
      ep_q <= '0;
      prod_q <= '0;
      idx_q <= '0;
      wt_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !fin_load) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          sel_q <= 1'b0;
          if (!q_empty_i) state_q <= StMul1;
        end
        StMul1: begin
          lw_q <= 21'(len) * 21'(w);
          state_q <= StMul2;
        end
        StMul2: begin
          d_q <= 29'(lw_q) * 29'(w);
          rem_q <= '0;
          quo_q <= sel_q ? pair_i.position_sum : pair_i.feature_sum;
          cnt_q <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          rem_q <= ge ? (rem_sh - dvs) : rem_sh;
          quo_q <= {quo_q[SumW-2:0], ge};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(SumW - 1)) state_q <= StLog;
        end
        StLog: begin
          t_q <= 27'((xt + 47'(64'd1 << 19)) >> 20);
          acc_q <= 32'h8000_0000;
          cnt_q <= '0;
          state_q <= StExp;
        end
        StExp: begin
          if (t_q[5'(FracBits - 1) - k]) acc_q <= 32'((accp + (64'd1 << 30)) >> 31);
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(FracBits - 1)) state_q <= StShift;
        end
        StShift: begin
          if (sel_q) begin
            ep_q <= kval;
            state_q <= StProd;
          end else begin
            ef_q <= kval;
            sel_q <= 1'b1;
            state_q <= StMul1;
          end
        end
        StProd: begin
          prod_q <= 63'(ef_q) * 63'(ep_q);
          state_q <= StFin;
        end
        StFin: begin
          if (fin_load) begin
            out_valid_q <= 1'b1;
            idx_q <= pair_i.entry_index;
            wt_q <= wround[16] ? 16'hFFFF : wround[15:0];
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `GPA_ASSERT(pop_needs_item, !pop_o || !q_empty_i)
  `GPA_ASSERT(div_count_range, state_q != StDiv || cnt_q < 6'(SumW))
  `GPA_ASSERT_NEXT(fin_sets_valid, fin_load, out_valid_q && state_q == StIdle)
endmodule

// ----- hdl/gaussian_pair_affinity.sv -----
`timescale 1ns / 1ps
// Gaussian pair affinity: element pairs of two patches stream in at one item per
// clock and are accumulated as squared differences into a feature and a position
// sum; on the last element of an off-diagonal pair the sums go to a two-entry queue
// and a back end computes the Q0.16 weight and flat index. The back end works on
// one pair at a time (two bit-serial divides and two 20-step table products),
// so input stalls only while two finished pairs are still waiting.
// Diagonal pairs produce no result. Configuration writes are accepted at any time
// and must be made only while the block is idle.
module gaussian_pair_affinity (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // elem_a, elem_b, row, col, zero pad
  input  logic        s_axis_tlast_i,  // last_of_pair
  input  logic        s_axis_tuser_i,  // is_position
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // entry_index, weight, zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  import gpa_pkg::*;

  cfg_t cfg_q;
  pair_t push_data, head;
  logic push, pop, q_full, q_empty;
  logic [19:0] entry_index;
  logic [15:0] weight;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.feature_length <= 13'd1;
      cfg_q.position_length <= 5'd2;
      cfg_q.feature_width <= 8'd1;
      cfg_q.position_width <= 8'd1;
      cfg_q.patch_count <= 11'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegFeatureLength: cfg_q.feature_length <= cfg_data_i;
        RegPositionLength: cfg_q.position_length <= cfg_data_i[4:0];
        RegFeatureWidth: cfg_q.feature_width <= cfg_data_i[7:0];
        RegPositionWidth: cfg_q.position_width <= cfg_data_i[7:0];
        RegPatchCount: cfg_q.patch_count <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  gpa_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .elem_a_i       (s_axis_tdata_i[15:0]),
    .elem_b_i       (s_axis_tdata_i[31:16]),
    .is_position_i  (s_axis_tuser_i),
    .last_of_pair_i (s_axis_tlast_i),
    .row_i          (s_axis_tdata_i[41:32]),
    .col_i          (s_axis_tdata_i[51:42]),
    .patch_count_i  (cfg_q.patch_count),
    .q_full_i       (q_full),
    .push_o         (push),
    .pair_o         (push_data)
  );

  gpa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  gpa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_empty_i     (q_empty),
    .pair_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .entry_index_o (entry_index),
    .weight_o      (weight)
  );

  assign m_axis_tdata_o = {4'd0, weight, entry_index};
endmodule

// ----- dv/tb_gaussian_pair_affinity.sv -----
`timescale 1ns / 1ps
module tb_gaussian_pair_affinity;
  import gpa_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned HoldCycles = 3000;
  localparam int unsigned DrainCycles = 400;
  localparam logic [2:0] RegUnused = 3'd7;
  localparam longint unsigned SumCap = (64'd1 << SumW) - 1;
  localparam longint unsigned ArgCap = (64'd1 << 26) - 1;

  typedef struct {
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    bit                 is_pos;
    bit                 last;
    logic [9:0]         row;
    logic [9:0]         col;
  } elem_t;

  typedef struct {
    logic [19:0] entry_index;
    logic [15:0] weight;
  } entry_t;

  typedef struct {
    elem_t  it;
    bit     typed;
    entry_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;

  gaussian_pair_affinity dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  longint unsigned root_q31[FracBits];
  longint unsigned feat_acc, pos_acc;
  longint unsigned fl_reg, pl_reg, fw_reg, pw_reg, pc_reg;

  entry_t     entry_q[$];
  bit         typed_q[$];
  entry_t     typed_val_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned hold_left = 0;
  int unsigned pat_cnt = 0;
  int unsigned pat_mode = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned sent = 0;

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // exp(-sum / (2^24 * len * w^2)) in q1.31
  function automatic longint unsigned heat_q31(longint unsigned s, longint unsigned len,
                                               longint unsigned w);
    longint unsigned d, x, t, f, acc, n;
    if (len == 0) len = 1;
    if (w == 0) w = 1;
    d = len * w * w;
    x = s / (d << 4);
    if (x > ArgCap) x = ArgCap;
    t = (x * longint'(Log2eQ20) + (64'd1 << 19)) >> FracBits;
    n = t >> FracBits;
    f = t & ((64'd1 << FracBits) - 1);
    if (n >= 32) return 0;
    acc = 64'd1 << 31;
    for (int k = 0; k < FracBits; k++) begin
      if (f[FracBits-1-k]) acc = (acc * root_q31[k] + (64'd1 << 30)) >> 31;
    end
    return acc >> n;
  endfunction

  function automatic bit affinity_step(elem_t it, output entry_t res);
    longint signed diff;
    longint unsigned sq, fl, pc, ef, ep, prod, wt;
    diff = longint'(it.elem_a) - longint'(it.elem_b);
    if (diff < 0) diff = -diff;
    sq = diff * diff;
    if (it.is_pos) pos_acc = (pos_acc + sq > SumCap) ? SumCap : pos_acc + sq;
    else feat_acc = (feat_acc + sq > SumCap) ? SumCap : feat_acc + sq;
    res = '{default: '0};
    if (!it.last) return 1'b0;
    fl = (fl_reg > MaxFeatureElems) ? MaxFeatureElems : fl_reg;
    pc = (pc_reg > MaxPatches) ? MaxPatches : pc_reg;
    ef = heat_q31(feat_acc, fl, fw_reg);
    ep = heat_q31(pos_acc, pl_reg, pw_reg);
    feat_acc = 0;
    pos_acc = 0;
    if (it.row == it.col) return 1'b0;
    prod = (ef * ep + (64'd1 << 30)) >> 31;
    wt = (prod + (64'd1 << 14)) >> 15;
    if (wt > 65535) wt = 65535;
    res.entry_index = 20'(longint'(it.row) + longint'(it.col) * pc);
    res.weight = wt[15:0];
    return 1'b1;
  endfunction

  function automatic elem_t mk_elem(int a, int b, bit p, bit l, int r, int c);
    elem_t e;
    e.elem_a = 16'(a);
    e.elem_b = 16'(b);
    e.is_pos = p;
    e.last = l;
    e.row = 10'(r);
    e.col = 10'(c);
    return e;
  endfunction

  // monitor: predicts on every accepted item and config write, and checks each accepted output
  always @(posedge clk_i) begin
    elem_t  it;
    entry_t res, got;
    bit     has, typed;
    entry_t tv;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegFeatureLength:  fl_reg = cfg_data_i;
        RegPositionLength: pl_reg = cfg_data_i[4:0];
        RegFeatureWidth:   fw_reg = cfg_data_i[7:0];
        RegPositionWidth:  pw_reg = cfg_data_i[7:0];
        RegPatchCount:     pc_reg = cfg_data_i[10:0];
        default: ;
      endcase
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      it.elem_a = s_axis_tdata_i[15:0];
      it.elem_b = s_axis_tdata_i[31:16];
      it.row = s_axis_tdata_i[41:32];
      it.col = s_axis_tdata_i[51:42];
      it.is_pos = s_axis_tuser_i;
      it.last = s_axis_tlast_i;
      typed = typed_q.pop_front();
      tv = typed_val_q.pop_front();
      has = affinity_step(it, res);
      if (has) entry_q.push_back(typed ? tv : res);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.entry_index = m_axis_tdata_o[19:0];
      got.weight = m_axis_tdata_o[35:20];
      if (entry_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected entry: index %0d weight %0d", got.entry_index, got.weight);
      end else begin
        res = entry_q.pop_front();
        if (got.entry_index !== res.entry_index || got.weight !== res.weight) begin
          mismatches++;
          if (mismatches <= 10)
            $display("entry mismatch: exp index %0d weight %0d, got index %0d weight %0d",
                     res.entry_index, res.weight, got.entry_index, got.weight);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: long hold-off on request, else a rotating stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      m_axis_tready_i <= 1'b0;
    end else begin
      pat_cnt <= pat_cnt + 1;
      if (pat_cnt % 97 == 0) pat_mode <= $urandom_range(0, 3);
      case (pat_mode)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= $urandom_range(0, 1);
        2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready_i <= (pat_cnt % 8 < 5);
      endcase
    end
  end

  task automatic send_elem(elem_t it, bit typed, entry_t want);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {4'd0, it.col, it.row, it.elem_b, it.elem_a};
    s_axis_tlast_i <= it.last;
    s_axis_tuser_i <= it.is_pos;
    typed_q.push_back(typed);
    typed_val_q.push_back(want);
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
    sent++;
    burst_left--;
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (entry_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 13'(val);
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
  endtask

  task automatic program_kernel(int unsigned fl, int unsigned pl, int unsigned fw,
                                int unsigned pw, int unsigned pc);
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    wait_idle();
    cfg_write(RegFeatureLength, fl);
    cfg_write(RegPositionLength, pl);
    cfg_write(RegFeatureWidth, fw);
    cfg_write(RegPositionWidth, pw);
    cfg_write(RegPatchCount, pc);
    if ($urandom_range(0, 1)) cfg_write(RegUnused, $urandom_range(0, 8191));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int near_value(int a);
    int sh;
    sh = $urandom_range(0, 15);
    return a + $signed($urandom_range(0, (1 << (sh + 1)) - 1)) - (1 << sh);
  endfunction

  // one patch pair: mostly well formed, sometimes noise of random shape
  task automatic send_pair();
    entry_t none;
    int n_feat, n_pos, total, a;
    int r, c;
    bit noisy;
    none = '{default: '0};
    noisy = ($urandom_range(0, 6) == 0);
    r = $urandom_range(0, 1023);
    c = ($urandom_range(0, 9) == 0) ? r : $urandom_range(0, 1023);
    n_feat = (fl_reg == 0) ? 1 : ((fl_reg > 12) ? $urandom_range(1, 6) : int'(fl_reg));
    n_pos = (pl_reg == 0) ? 1 : ((pl_reg > 8) ? $urandom_range(1, 4) : int'(pl_reg));
    if (noisy) begin
      n_feat = $urandom_range(0, 10);
      n_pos = $urandom_range(0, 6);
    end
    total = n_feat + n_pos;
    if (total == 0) total = 1;
    for (int i = 0; i < total; i++) begin
      elem_t e;
      a = $urandom_range(0, 65535) - 32768;
      if (!noisy && $urandom_range(0, 3) != 0) a = a / 8;
      e = mk_elem(a, noisy ? int'($urandom_range(0, 65535)) : near_value(a),
                  noisy ? bit'($urandom_range(0, 1)) : (i >= n_feat), i == total - 1,
                  r, c);
      send_elem(e, 1'b0, none);
    end
  endtask

  initial begin
    dir_row_t dir[$];
    entry_t none;
    none = '{default: '0};
    feat_acc = 0;
    pos_acc = 0;
    fl_reg = 1;
    pl_reg = 2;
    fw_reg = 1;
    pw_reg = 1;
    pc_reg = 2;
    begin
      longint unsigned cq;
      cq = 64'd1 << 30;
      for (int k = 0; k < FracBits; k++) begin
        cq = int_root(cq << 31);
        root_q31[k] = cq;
      end
    end

    // zero distance after reset gives full weight
    dir.push_back('{mk_elem(0, 0, 0, 1, 1, 0), 1, '{20'd1, 16'd65535}});
    // largest distance drives the weight to zero
    dir.push_back('{mk_elem(32767, -32768, 0, 1, 0, 1), 1, '{20'd2, 16'd0}});
    dir.push_back('{mk_elem(-32768, 32767, 1, 1, 1023, 1022), 1, '{20'd3067, 16'd0}});
    // diagonal pair, then check the sums were cleared
    dir.push_back('{mk_elem(5000, 1, 0, 0, 7, 7), 0, none});
    dir.push_back('{mk_elem(-3, 9, 1, 1, 7, 7), 0, none});
    dir.push_back('{mk_elem(100, 100, 0, 1, 3, 5), 1, '{20'd13, 16'd65535}});
    dir.push_back('{mk_elem(4096, 0, 0, 0, 2, 9), 0, none});
    dir.push_back('{mk_elem(0, 2048, 1, 0, 2, 9), 0, none});
    dir.push_back('{mk_elem(-4096, -4096, 1, 0, 2, 9), 0, none});
    dir.push_back('{mk_elem(1, -1, 0, 1, 2, 9), 0, none});
    dir.push_back('{mk_elem(2048, 0, 1, 1, 1023, 0), 0, none});
    dir.push_back('{mk_elem(-1, 0, 0, 1, 0, 1023), 0, none});
    // more elements than the lengths
    dir.push_back('{mk_elem(300, -300, 0, 0, 4, 6), 0, none});
    dir.push_back('{mk_elem(-700, 20, 0, 0, 4, 6), 0, none});
    dir.push_back('{mk_elem(90, 91, 1, 0, 4, 6), 0, none});
    dir.push_back('{mk_elem(12, 1200, 1, 0, 4, 6), 0, none});
    dir.push_back('{mk_elem(-5, 5, 1, 1, 4, 6), 0, none});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir[i]) send_elem(dir[i].it, dir[i].typed, dir[i].want);

    for (int ph = 0; ph < 9; ph++) begin
      int unsigned stop;
      case (ph)
        0: program_kernel(0, 0, 0, 0, 0);
        1: program_kernel(8191, 31, 255, 255, 2047);
        2: program_kernel(4096, 16, 255, 1, 1024);
        3: program_kernel(1, 1, 1, 255, 2);
        default: program_kernel($urandom_range(1, 12), $urandom_range(1, 8),
                                $urandom_range(1, 255), $urandom_range(1, 255),
                                $urandom_range(2, 1024));
      endcase
      if (ph == 5) hold_req = 1'b1;
      stop = sent + 210;
      while (sent < stop) send_pair();
    end

    s_axis_tvalid_i <= 1'b0;
    while (entry_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/gpa_pkg.sv
hdl/gpa_front.sv
hdl/gpa_fifo.sv
hdl/gpa_back.sv
hdl/gaussian_pair_affinity.sv
dv/tb_gaussian_pair_affinity.sv
